@@ hdl/dgts_pkg.sv @@
package dgts_pkg;

   // command codes of an input item
   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_ADD_NODE = 2'd1,
      CMD_ADD_EDGE = 2'd2,
      CMD_ORDER    = 2'd3
   } cmd_type;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_CAPACITY = 3'd2;
   localparam logic [2:0] ST_EXISTS   = 3'd3;
   localparam logic [2:0] ST_CYCLE    = 3'd4;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_EMIT,
      S_DUP_RD,
      S_DUP_CHK,
      S_APPEND,
      S_CLR,
      S_CNT_RD,
      S_CNT_NRD,
      S_CNT_WR,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_REM_RD,
      S_REM_NRD,
      S_REM_WR
   } state_type;

endpackage

@@ hdl/dependency_graph_topo_sort.sv @@
// Dependency graph store with topological ordering (Kahn, lowest index first).
// Request channel: req_valid / req_stall with req_cmd, req_from_node, req_to_node.
// Commands: clear, add node, add edge (checked for range, self loop, capacity and
// duplicates), order. Each command but order gives one result item with last set.
// Order gives one item per picked node, then a last item with status ok or cycle
// and the count of ordered nodes.
// Response channel: rsp_valid / rsp_stall; results sit in an output register and
// hold while rsp_stall is high; the sequencer waits until that register is free.
// One command is worked on at a time: req_stall is high while a command runs.
// Add edge reads the stored edges one by one to check for a duplicate.
// Order clears the whole node memory, counts in-degrees over all edges, then for
// each picked node scans the nodes from index 0 and walks all stored edges.
// Reset (synchronous, active high) empties the graph and the output register.
module dependency_graph_topo_sort
   import dgts_pkg::*;
#(
   parameter int MAX_NODES = 32,
   parameter int MAX_EDGES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [4:0] req_from_node,
   input  logic [4:0] req_to_node,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_node_index,
   output logic [5:0] rsp_order_count,
   output logic       rsp_last
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int NTW = $clog2(MAX_NODES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ETW = $clog2(MAX_EDGES + 1);

   typedef struct packed {
      logic [ETW-1:0] indeg;
      logic           picked;
   } node_entry_type;

   // state and datapath registers
   state_type      state_ff, state_in;
   state_type      ret_ff, ret_in;
   logic [NTW-1:0] node_total_ff, node_total_in;
   logic [ETW-1:0] edge_total_ff, edge_total_in;
   logic [EAW-1:0] e_ff, e_in;
   logic [NTW-1:0] i_ff, i_in;
   logic [NTW-1:0] n_ff, n_in;
   logic [NW-1:0]  pick_ff, pick_in;
   logic [NW-1:0]  t_ff, t_in;
   logic [4:0]     a_ff, a_in, b_ff, b_in;
   logic [2:0]     res_status_ff, res_status_in;
   logic [4:0]     res_node_ff, res_node_in;
   logic [5:0]     res_count_ff, res_count_in;
   logic           res_last_ff, res_last_in;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [4:0]     rsp_node_ff;
   logic [5:0]     rsp_count_ff;
   logic           rsp_last_ff;

   // memories
   logic [9:0]     edge_mem [MAX_EDGES];
   node_entry_type node_mem [MAX_NODES];
   logic [9:0]     edge_q_ff;
   node_entry_type node_q_ff;
   logic           edge_we;
   logic [9:0]     edge_wdata;
   logic           node_we;
   logic [NW-1:0]  node_waddr;
   node_entry_type node_wdata;
   logic [EAW-1:0] edge_raddr;
   logic [NW-1:0]  node_raddr;

   // helper conditions
   logic           req_accept;
   logic           out_free;
   logic           edge_is_last;
   logic           add_invalid;
   logic           add_full;
   logic           src_match;
   logic           can_pick;
   logic [4:0]     q_src, q_tgt;

   assign req_accept   = req_valid && !req_stall;
   assign req_stall    = (state_ff != S_IDLE);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign q_src        = edge_q_ff[9:5];
   assign q_tgt        = edge_q_ff[4:0];
   assign edge_is_last = (ETW'(e_ff) + ETW'(1)) == edge_total_ff;
   assign add_invalid  = (10'(req_from_node) >= 10'(node_total_ff)) ||
                         (10'(req_to_node) >= 10'(node_total_ff)) ||
                         (req_from_node == req_to_node);
   assign add_full     = (edge_total_ff >= ETW'(MAX_EDGES));
   assign src_match    = (NW'(q_src) == pick_ff);
   assign can_pick     = !node_q_ff.picked && (node_q_ff.indeg == '0);
   assign edge_raddr   = e_ff;
   assign node_raddr   = (state_ff == S_CNT_NRD || state_ff == S_REM_NRD) ?
                         NW'(q_tgt) : NW'(i_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR:    state_in = S_EMIT;
                  CMD_ADD_NODE: state_in = S_EMIT;
                  CMD_ADD_EDGE: begin
                     if (add_invalid || add_full) state_in = S_EMIT;
                     else if (edge_total_ff == '0) state_in = S_APPEND;
                     else state_in = S_DUP_RD;
                  end
                  CMD_ORDER:    state_in = S_CLR;
               endcase
            end
         end
         S_EMIT:     if (out_free) state_in = ret_ff;
         S_DUP_RD:   state_in = S_DUP_CHK;
         S_DUP_CHK: begin
            if (edge_q_ff == {a_ff, b_ff}) state_in = S_EMIT;
            else if (edge_is_last) state_in = S_APPEND;
            else state_in = S_DUP_RD;
         end
         S_APPEND:   state_in = S_EMIT;
         S_CLR: begin
            if (i_ff == NTW'(MAX_NODES - 1))
               state_in = (edge_total_ff == '0) ? S_SCAN_RD : S_CNT_RD;
         end
         S_CNT_RD:   state_in = S_CNT_NRD;
         S_CNT_NRD:  state_in = S_CNT_WR;
         S_CNT_WR:   state_in = edge_is_last ? S_SCAN_RD : S_CNT_RD;
         S_SCAN_RD: begin
            if (n_ff == node_total_ff || i_ff == node_total_ff) state_in = S_EMIT;
            else state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: state_in = can_pick ? S_EMIT : S_SCAN_RD;
         S_REM_RD:   state_in = S_REM_NRD;
         S_REM_NRD: begin
            if (src_match) state_in = S_REM_WR;
            else state_in = edge_is_last ? S_SCAN_RD : S_REM_RD;
         end
         S_REM_WR:   state_in = edge_is_last ? S_SCAN_RD : S_REM_RD;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      ret_in        = ret_ff;
      node_total_in = node_total_ff;
      edge_total_in = edge_total_ff;
      e_in          = e_ff;
      i_in          = i_ff;
      n_in          = n_ff;
      pick_in       = pick_ff;
      t_in          = t_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_count_in  = res_count_ff;
      res_last_in   = res_last_ff;
      edge_we       = 1'b0;
      edge_wdata    = {a_ff, b_ff};
      node_we       = 1'b0;
      node_waddr    = NW'(i_ff);
      node_wdata    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               a_in          = req_from_node;
               b_in          = req_to_node;
               e_in          = '0;
               i_in          = '0;
               n_in          = '0;
               ret_in        = S_IDLE;
               res_status_in = ST_OK;
               res_node_in   = '0;
               res_count_in  = '0;
               res_last_in   = 1'b1;
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     node_total_in = '0;
                     edge_total_in = '0;
                  end
                  CMD_ADD_NODE: begin
                     if (node_total_ff >= NTW'(MAX_NODES)) res_status_in = ST_CAPACITY;
                     else node_total_in = node_total_ff + NTW'(1);
                  end
                  CMD_ADD_EDGE: begin
                     if (add_invalid) res_status_in = ST_INVALID;
                     else if (add_full) res_status_in = ST_CAPACITY;
                  end
                  CMD_ORDER: ;
               endcase
            end
         end
         S_EMIT: ;
         S_DUP_RD: ;
         S_DUP_CHK: begin
            if (edge_q_ff == {a_ff, b_ff}) res_status_in = ST_EXISTS;
            else e_in = e_ff + EAW'(1);
         end
         // store the new edge at the end of the list
         S_APPEND: begin
            edge_we       = 1'b1;
            edge_total_in = edge_total_ff + ETW'(1);
            res_status_in = ST_OK;
         end
         // wipe the node working store
         S_CLR: begin
            node_we = 1'b1;
            if (i_ff == NTW'(MAX_NODES - 1)) begin
               i_in = '0;
               e_in = '0;
            end else begin
               i_in = i_ff + NTW'(1);
            end
         end
         S_CNT_RD: ;
         S_CNT_NRD: t_in = NW'(q_tgt);
         // count in-degree of each edge target
         S_CNT_WR: begin
            node_we          = 1'b1;
            node_waddr       = t_ff;
            node_wdata       = node_q_ff;
            node_wdata.indeg = node_q_ff.indeg + ETW'(1);
            e_in             = edge_is_last ? '0 : e_ff + EAW'(1);
         end
         // finish when all nodes are ordered or none is free
         S_SCAN_RD: begin
            ret_in       = S_IDLE;
            res_node_in  = '0;
            res_count_in = 6'(n_ff);
            res_last_in  = 1'b1;
            res_status_in = (n_ff == node_total_ff) ? ST_OK : ST_CYCLE;
         end
         // pick the lowest free node with no pending prerequisite
         S_SCAN_CHK: begin
            if (can_pick) begin
               node_we        = 1'b1;
               node_wdata     = node_q_ff;
               node_wdata.picked = 1'b1;
               pick_in        = NW'(i_ff);
               n_in           = n_ff + NTW'(1);
               res_status_in  = ST_OK;
               res_node_in    = 5'(i_ff);
               res_count_in   = 6'(n_ff + NTW'(1));
               res_last_in    = 1'b0;
               ret_in         = (edge_total_ff == '0) ? S_SCAN_RD : S_REM_RD;
               i_in           = '0;
               e_in           = '0;
            end else begin
               i_in = i_ff + NTW'(1);
            end
         end
         S_REM_RD: ;
         S_REM_NRD: begin
            if (src_match) t_in = NW'(q_tgt);
            else e_in = edge_is_last ? '0 : e_ff + EAW'(1);
         end
         // lower the in-degree of each target of the picked node's outgoing edges
         S_REM_WR: begin
            node_waddr = t_ff;
            node_wdata = node_q_ff;
            if (node_q_ff.indeg != '0) begin
               node_we          = 1'b1;
               node_wdata.indeg = node_q_ff.indeg - ETW'(1);
            end
            e_in = edge_is_last ? '0 : e_ff + EAW'(1);
         end
         default: ;
      endcase
   end

   // edge and node memories, registered reads
   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[EAW'(edge_total_ff)] <= edge_wdata;
      if (node_we) node_mem[node_waddr] <= node_wdata;
      edge_q_ff <= edge_mem[edge_raddr];
      node_q_ff <= node_mem[node_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         node_total_ff <= '0;
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         node_total_ff <= node_total_in;
         edge_total_ff <= edge_total_in;
         if (state_ff == S_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      e_ff          <= e_in;
      i_ff          <= i_in;
      n_ff          <= n_in;
      pick_ff       <= pick_in;
      t_ff          <= t_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_count_ff  <= res_count_in;
      res_last_ff   <= res_last_in;
      if (state_ff == S_EMIT && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_node_ff   <= res_node_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_node_index  = rsp_node_ff;
   assign rsp_order_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= ETW'(MAX_EDGES))
      else $error("edge count beyond capacity");
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      node_total_ff <= NTW'(MAX_NODES))
      else $error("node count beyond capacity");
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK)
      else $error("non-last item without ok status");
   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_RD |-> n_ff <= node_total_ff)
      else $error("more nodes ordered than stored");

endmodule

@@ sim/tb_dependency_graph_topo_sort.sv @@
`timescale 1ns / 1ps

// expected result of one graph operation
typedef struct packed {
   logic [2:0] status;
   logic [4:0] node_index;
   logic [5:0] order_count;
   logic       last;
} graph_rsp_type;

class graph_scoreboard;
   int unsigned   node_total;
   int unsigned   edge_total;
   logic [4:0]    edge_from [64];
   logic [4:0]    edge_to [64];
   graph_rsp_type pending [$];
   int            mismatches;

   function new();
      node_total = 0;
      edge_total = 0;
      mismatches = 0;
   endfunction

   function void push_rsp(logic [2:0] st, logic [4:0] nd, logic [5:0] cnt, logic lst);
      graph_rsp_type r;
      r.status = st;
      r.node_index = nd;
      r.order_count = cnt;
      r.last = lst;
      pending.push_back(r);
   endfunction

   // kahn order with lowest index picked first
   function void predict_order();
      int unsigned indeg [32];
      bit          picked [32];
      int unsigned n;
      int          pick;
      for (int i = 0; i < 32; i++) begin
         indeg[i] = 0;
         picked[i] = 0;
      end
      for (int e = 0; e < edge_total; e++) indeg[edge_to[e]]++;
      n = 0;
      while (n < node_total) begin
         pick = -1;
         for (int i = 0; i < node_total; i++) begin
            if (!picked[i] && indeg[i] == 0) begin
               pick = i;
               break;
            end
         end
         if (pick < 0) begin
            push_rsp(dgts_pkg::ST_CYCLE, 5'd0, 6'(n), 1'b1);
            return;
         end
         picked[pick] = 1;
         n++;
         push_rsp(dgts_pkg::ST_OK, 5'(pick), 6'(n), 1'b0);
         for (int e = 0; e < edge_total; e++)
            if (edge_from[e] == pick && indeg[edge_to[e]] > 0) indeg[edge_to[e]]--;
      end
      push_rsp(dgts_pkg::ST_OK, 5'd0, 6'(n), 1'b1);
   endfunction

   // note an accepted item
   function void note_item(dgts_pkg::cmd_type cmd, logic [4:0] a, logic [4:0] b);
      logic [2:0] st;
      case (cmd)
         dgts_pkg::CMD_CLEAR: begin
            node_total = 0;
            edge_total = 0;
            push_rsp(dgts_pkg::ST_OK, 5'd0, 6'd0, 1'b1);
         end
         dgts_pkg::CMD_ADD_NODE: begin
            if (node_total >= 32) st = dgts_pkg::ST_CAPACITY;
            else begin
               node_total++;
               st = dgts_pkg::ST_OK;
            end
            push_rsp(st, 5'd0, 6'd0, 1'b1);
         end
         dgts_pkg::CMD_ADD_EDGE: begin
            if (a >= node_total || b >= node_total || a == b) st = dgts_pkg::ST_INVALID;
            else if (edge_total >= 64) st = dgts_pkg::ST_CAPACITY;
            else begin
               st = dgts_pkg::ST_OK;
               for (int e = 0; e < edge_total; e++)
                  if (edge_from[e] == a && edge_to[e] == b) st = dgts_pkg::ST_EXISTS;
               if (st == dgts_pkg::ST_OK) begin
                  edge_from[edge_total] = a;
                  edge_to[edge_total] = b;
                  edge_total++;
               end
            end
            push_rsp(st, 5'd0, 6'd0, 1'b1);
         end
         default: predict_order();
      endcase
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endfunction

   // compare a result with the oldest expectation
   function void check_rsp(graph_rsp_type got);
      graph_rsp_type exp_r;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result %p", got));
         return;
      end
      exp_r = pending.pop_front();
      if (got.status != exp_r.status)
         report($sformatf("status %0d want %0d", got.status, exp_r.status));
      if (got.node_index != exp_r.node_index)
         report($sformatf("node_index %0d want %0d", got.node_index, exp_r.node_index));
      if (got.order_count != exp_r.order_count)
         report($sformatf("order_count %0d want %0d", got.order_count, exp_r.order_count));
      if (got.last != exp_r.last)
         report($sformatf("last %0d want %0d", got.last, exp_r.last));
   endfunction
endclass

module tb_dependency_graph_topo_sort;
   import dgts_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic [1:0] req_cmd = 0;
   logic [4:0] req_from_node = 0;
   logic [4:0] req_to_node = 0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic [2:0] rsp_status;
   logic [4:0] rsp_node_index;
   logic [5:0] rsp_order_count;
   logic       rsp_last;

   graph_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 0;
   bit  stim_done = 0;
   int  quiet_cycles = 0;

   always #6 clock = ~clock;

   dependency_graph_topo_sort dut (.*);

   // note accepted items and check results at the rising edge
   always @(posedge clock) begin
      graph_rsp_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_item(cmd_type'(req_cmd), req_from_node, req_to_node);
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.node_index = rsp_node_index;
            got.order_count = rsp_order_count;
            got.last = rsp_last;
            sb.check_rsp(got);
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 200000) begin
         $display("tb_dependency_graph_topo_sort failed");
         $finish;
      end
   end

   // offer one item and wait for its acceptance; valid stays up for a following item
   task automatic send_item(cmd_type cmd, logic [4:0] a, logic [4:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_from_node <= a;
      req_to_node <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic add_nodes(int count);
      for (int i = 0; i < count; i++) send_item(CMD_ADD_NODE, 5'd0, 5'd0);
   endtask

   // graph build with random edges, some of them refused, then an order
   task automatic random_graph();
      int nodes;
      int edges;
      logic [4:0] a;
      logic [4:0] b;
      nodes = ($urandom_range(9) == 0) ? $urandom_range(32, 20) : $urandom_range(8, 1);
      edges = $urandom_range(nodes + 2);
      send_item(CMD_CLEAR, 5'($urandom), 5'($urandom));
      add_nodes(nodes);
      for (int e = 0; e < edges; e++) begin
         a = 5'($urandom_range(nodes - 1));
         b = 5'($urandom_range(nodes - 1));
         // mostly forward edges, so most graphs are acyclic
         if ($urandom_range(3) != 0 && a > b) begin
            a = a ^ b;
            b = a ^ b;
            a = a ^ b;
         end
         if ($urandom_range(9) == 0) a = 5'($urandom);
         send_item(CMD_ADD_EDGE, a, b);
      end
      send_item(CMD_ORDER, 5'($urandom), 5'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty order, refusals, cycle, full stores
      send_item(CMD_ORDER, 5'd31, 5'd31);
      send_item(CMD_ADD_EDGE, 5'd0, 5'd1);
      add_nodes(3);
      send_item(CMD_ADD_EDGE, 5'd1, 5'd1);
      send_item(CMD_ADD_EDGE, 5'd0, 5'd31);
      send_item(CMD_ADD_EDGE, 5'd2, 5'd0);
      send_item(CMD_ADD_EDGE, 5'd2, 5'd0);
      send_item(CMD_ADD_EDGE, 5'd0, 5'd1);
      send_item(CMD_ORDER, 5'd0, 5'd0);
      send_item(CMD_ADD_EDGE, 5'd1, 5'd2);
      send_item(CMD_ORDER, 5'd0, 5'd0);
      send_item(CMD_CLEAR, 5'd31, 5'd31);
      add_nodes(33);
      send_item(CMD_ADD_EDGE, 5'd31, 5'd30);
      for (int i = 0; i < 64; i++) send_item(CMD_ADD_EDGE, 5'(i % 31 + 1), 5'(i / 31));
      send_item(CMD_ADD_EDGE, 5'd5, 5'd9);
      send_item(CMD_ORDER, 5'd0, 5'd0);

      // receiver holds off while items keep coming
      hold_off = 1;
      fork
         begin
            repeat (3000) @(negedge clock);
            hold_off = 0;
         end
         begin
            send_item(CMD_CLEAR, 5'd0, 5'd0);
            add_nodes(6);
         end
      join

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 47) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 47) : 0;
         for (int g = 0; g < 3; g++) random_graph();
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0) $display("tb_dependency_graph_topo_sort passed");
      else $display("tb_dependency_graph_topo_sort failed");
      $finish;
   end
endmodule
